/* rtl/crc16a_pkg.sv */
// Package for the augmented, reflected-input CRC-16 block.
// Holds the remainder beat type, the reset polynomial and the bit-step functions.
// No dependencies.
`default_nettype none

package crc16a_pkg;

  localparam int unsigned CRC_WIDTH = 16;
  localparam int unsigned BYTE_WIDTH = 8;
  localparam logic [CRC_WIDTH-1:0] POLY_RESET = 16'h8006;

  typedef logic [CRC_WIDTH-1:0] crc_t;

  // One remainder moving down the augmentation pipeline.
  typedef struct packed {
    logic valid;
    crc_t rem;
  } rem_beat_t;

  // Shifts eight bits into the remainder, least significant bit of the byte first.
  // The polynomial is XORed in whenever the bit shifted out of the top is one.
  function automatic crc_t crc16a_step8(input crc_t rem_in, input logic [BYTE_WIDTH-1:0] bits,
                                        input crc_t poly);
    crc_t r;
    logic out_bit;
    r = rem_in;
    for (int i = 0; i < BYTE_WIDTH; i++) begin
      out_bit = r[CRC_WIDTH-1];
      r = {r[CRC_WIDTH-2:0], bits[i]};
      if (out_bit) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  function automatic crc_t crc16a_reverse(input crc_t v);
    crc_t res;
    for (int i = 0; i < CRC_WIDTH; i++) begin
      res[i] = v[CRC_WIDTH-1-i];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/crc16a_byte_stage.sv */
// Byte stage: holds the running remainder and folds one message byte into it per request.
// On the last byte it hands the remainder on to the augmentation stages. Uses crc16a_pkg.
`default_nettype none

module crc16a_byte_stage
  import crc16a_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [BYTE_WIDTH-1:0] data_byte,
  input  wire logic                  last,
  input  wire crc_t                  polynomial,
  output      rem_beat_t             down,
  input  wire logic                  down_ready
);

  crc_t remainder;
  crc_t remainder_next;
  logic held_valid;
  crc_t held_rem;
  logic accept;

  assign in_ready       = !held_valid || down_ready;
  assign accept         = in_valid && in_ready;
  assign remainder_next = crc16a_step8(remainder, data_byte, polynomial);

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder  <= '0;
      held_valid <= 1'b0;
    end else begin
      if (accept) begin
        // The remainder restarts from zero once a message is complete.
        remainder <= last ? '0 : remainder_next;
      end
      if (in_ready) begin
        held_valid <= accept && last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      held_rem <= remainder_next;
    end
  end

  assign down.valid = held_valid;
  assign down.rem   = held_rem;

endmodule

`default_nettype wire

/* rtl/crc16a_aug_stage.sv */
// Augmentation stage: shifts eight zero bits through a finished remainder.
// Two of these in a row give the sixteen augmenting zeros. Uses crc16a_pkg.
`default_nettype none

module crc16a_aug_stage
  import crc16a_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire rem_beat_t up,
  output      logic      up_ready,
  input  wire crc_t      polynomial,
  output      rem_beat_t down,
  input  wire logic      down_ready
);

  logic held_valid;
  crc_t held_rem;

  assign up_ready = !held_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (up_ready) begin
      held_valid <= up.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up.valid && up_ready) begin
      held_rem <= crc16a_step8(up.rem, '0, polynomial);
    end
  end

  assign down.valid = held_valid;
  assign down.rem   = held_rem;

endmodule

`default_nettype wire

/* rtl/crc16_augmented_reflected.sv */
// Three register stages lie between an accepted last byte and out_valid: the byte stage's
// held remainder, then the first and the second augmentation stage.
// Throughput: one byte per cycle while in_ready is high; the remainder updates per byte.
// Each stage holds one CRC; input closes only when all three hold one and the output stalls.
// Reset (rst, synchronous) clears the remainder and all valid flags, and loads 0x8006.
// Top level of the augmented, reflected-input CRC-16. Uses crc16a_pkg and the stage modules.
`default_nettype none

module crc16_augmented_reflected
  import crc16a_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CRC_WIDTH-1:0]  cfg_wdata,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [BYTE_WIDTH-1:0] data_byte,
  input  wire logic                  last,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [CRC_WIDTH-1:0]  crc_value
);

  crc_t      polynomial;
  rem_beat_t byte_beat;
  rem_beat_t aug_beat;
  rem_beat_t out_beat;
  logic      aug0_ready;
  logic      aug1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial <= POLY_RESET;
    end else if (cfg_we) begin
      polynomial <= cfg_wdata;
    end
  end

  crc16a_byte_stage u_byte (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last       (last),
    .polynomial (polynomial),
    .down       (byte_beat),
    .down_ready (aug0_ready)
  );

  crc16a_aug_stage u_aug0 (
    .clk        (clk),
    .rst        (rst),
    .up         (byte_beat),
    .up_ready   (aug0_ready),
    .polynomial (polynomial),
    .down       (aug_beat),
    .down_ready (aug1_ready)
  );

  // The second stage's register is the output register.
  crc16a_aug_stage u_aug1 (
    .clk        (clk),
    .rst        (rst),
    .up         (aug_beat),
    .up_ready   (aug1_ready),
    .polynomial (polynomial),
    .down       (out_beat),
    .down_ready (out_ready)
  );

  assign out_valid = out_beat.valid;
  assign crc_value = crc16a_reverse(out_beat.rem);

endmodule

`default_nettype wire

/* rtl/crc16a_checker.sv */
// Port-level checks for crc16_augmented_reflected, attached by the bind below.
// Depends only on the top level's ports.
`default_nettype none

module crc16a_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] crc_value
);

  // Reset leaves the block empty and open for requests.
  a_reset_empty: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("block not empty and ready after reset");

  // Input can only close when a finished CRC is held back at the output.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while the output is not blocked");

  // A refused result stays, unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(crc_value))
    else $error("result dropped or changed while stalled");

endmodule

bind crc16_augmented_reflected crc16a_checker u_crc16a_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .crc_value (crc_value)
);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for crc16_augmented_reflected: directed table, then random messages.
// Predicts each CRC with its own bitwise model of the augmented, reflected-input CRC-16.
// Depends on rtl/crc16a_pkg.sv and rtl/crc16_augmented_reflected.sv.
`default_nettype none

module testbench
  import crc16a_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 10;
  localparam int N_ROWS = 21;
  localparam int SEG_BYTES = 108;

  typedef enum logic {ROW_BYTE, ROW_POLY} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [15:0] value;
    logic is_last;
    bit typed;
    crc_t want;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CRC_WIDTH-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [BYTE_WIDTH-1:0] data_byte = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CRC_WIDTH-1:0] crc_value;

  // Predictor state: the running remainder and the polynomial last written.
  crc_t msg_remainder = '0;
  crc_t cur_poly = POLY_RESET;
  crc_t crc_expected_q[$];

  int src_idle_pct = 38;
  int sink_idle_pct = 75;
  int err_count = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int crcs_checked = 0;
  int poly_writes = 0;

  vec_row_t dir_rows [N_ROWS];

  crc16_augmented_reflected DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .crc_value(crc_value)
  );

  always #4 clk = ~clk;

  initial begin
    #5ms;
    $display("Timeout: %0d CRCs still outstanding", crc_expected_q.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_error(input string msg);
    err_count++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // One bit step: the bit enters at the bottom, and the polynomial is folded in
  // when the bit leaving the top was one.
  function automatic crc_t shift_one(input crc_t r, input logic b);
    logic msb;
    msb = r[CRC_WIDTH-1];
    r = {r[CRC_WIDTH-2:0], b};
    if (msb) begin
      r = r ^ cur_poly;
    end
    return r;
  endfunction

  function automatic crc_t mirror16(input crc_t v);
    crc_t res;
    for (int i = 0; i < CRC_WIDTH; i++) begin
      res[i] = v[CRC_WIDTH-1-i];
    end
    return res;
  endfunction

  // Folds one byte into the message remainder. Returns 1 and the CRC on the last byte.
  function automatic bit fold_byte(input logic [BYTE_WIDTH-1:0] d, input logic l,
                                   output crc_t crc);
    crc_t r;
    r = msg_remainder;
    crc = '0;
    for (int i = 0; i < BYTE_WIDTH; i++) begin
      r = shift_one(r, d[i]);
    end
    if (!l) begin
      msg_remainder = r;
      return 1'b0;
    end
    for (int i = 0; i < CRC_WIDTH; i++) begin
      r = shift_one(r, 1'b0);
    end
    crc = mirror16(r);
    msg_remainder = '0;
    return 1'b1;
  endfunction

  // Presents one request and waits until it is taken. A valid that stays high for
  // the next request is not lowered in between.
  task automatic send_byte(input logic [BYTE_WIDTH-1:0] d, input logic l, input bit typed,
                           input crc_t want);
    crc_t crc;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    last <= l;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (fold_byte(d, l, crc)) begin
      crc_expected_q = {crc_expected_q, (typed ? want : crc)};
      msgs_sent++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (crc_expected_q.size() != 0) @(posedge clk);
    // A byte without last gives no result, so leave time for the pipeline to empty.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_poly(input crc_t p);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_poly = p;
    poly_writes++;
  endtask

  function automatic logic [BYTE_WIDTH-1:0] pick_byte();
    case ($urandom_range(9))
      0: pick_byte = 8'h00;
      1: pick_byte = 8'hFF;
      default: pick_byte = BYTE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_message();
    int len;
    if ($urandom_range(19) == 0) begin
      len = $urandom_range(24, 64);
    end else if ($urandom_range(3) == 0) begin
      len = 1;
    end else begin
      len = $urandom_range(2, 12);
    end
    for (int i = 0; i < len; i++) begin
      send_byte(pick_byte(), i == len - 1, 1'b0, '0);
    end
  endtask

  // Result side: check every accepted CRC, then decide whether to stall next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (crc_expected_q.size() == 0) begin
        report_error($sformatf("unexpected CRC 0x%04h", crc_value));
      end else begin
        crc_t exp_crc;
        exp_crc = crc_expected_q.pop_front();
        crcs_checked++;
        if (crc_value !== exp_crc) begin
          report_error($sformatf("crc_value 0x%04h, expected 0x%04h", crc_value, exp_crc));
        end
      end
    end
    out_ready <= !rst && ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    int seg_start;
    crc_t seg_poly;
    // With a zero polynomial the message is shifted out entirely, so the CRC is zero.
    dir_rows = '{
      '{ROW_BYTE, 16'h0000, 1'b1, 1'b1, 16'h0000},
      '{ROW_BYTE, 16'h00FF, 1'b1, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h0001, 1'b1, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h0080, 1'b1, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h00A5, 1'b0, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h005A, 1'b0, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h00FF, 1'b0, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h0000, 1'b1, 1'b0, 16'h0000},
      '{ROW_POLY, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h00FF, 1'b1, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h0055, 1'b1, 1'b0, 16'h0000},
      '{ROW_POLY, 16'h0000, 1'b0, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h00C3, 1'b1, 1'b1, 16'h0000},
      '{ROW_BYTE, 16'h00FF, 1'b0, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h00FF, 1'b1, 1'b1, 16'h0000},
      '{ROW_POLY, POLY_RESET, 1'b0, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h007E, 1'b0, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h0081, 1'b1, 1'b0, 16'h0000},
      '{ROW_POLY, 16'h0001, 1'b0, 1'b0, 16'h0000},
      '{ROW_BYTE, 16'h0080, 1'b1, 1'b0, 16'h0000}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_POLY) begin
        load_poly(dir_rows[i].value);
      end else begin
        send_byte(dir_rows[i].value[BYTE_WIDTH-1:0], dir_rows[i].is_last, dir_rows[i].typed,
                  dir_rows[i].want);
      end
    end

    // Three idling patterns, each walked through four polynomial settings.
    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      src_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 75 : 0;
      sink_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 38 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        case (seg)
          0: seg_poly = crc_t'($urandom);
          1: seg_poly = (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000 : POLY_RESET;
          2: seg_poly = crc_t'($urandom);
          default: seg_poly = 16'h1021;
        endcase
        load_poly(seg_poly);
        seg_start = bytes_sent;
        while (bytes_sent - seg_start < SEG_BYTES) begin
          send_message();
        end
      end
    end

    wait_idle();
    $display("Sent %0d bytes in %0d messages over %0d polynomial writes; %0d CRCs checked.",
             bytes_sent, msgs_sent, poly_writes, crcs_checked);
    $display("Idling covered sender-heavy, receiver-heavy and back-to-back traffic.");
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches found", err_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
